// ----- hw/rtl/swdg_pkg.sv -----
// Shared types for the stuck sensor data watchdog.
// Holds the function codes, the input item record and the channel update record.
// No dependencies.
package swdg_pkg;

  localparam int unsigned HashW    = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IdW      = 8;
  localparam int unsigned MaskW    = 8;
  localparam logic [TimeW-1:0] WindowReset = 32'd60000;

  // Function codes of an input item
  typedef enum logic [1:0] {
    FuncFeed  = 2'd0,
    FuncTick  = 2'd1,
    FuncCheck = 2'd2
  } func_e;

  // One input item as held in the input register
  typedef struct packed {
    func_e             func;
    logic [IdW-1:0]    sensor_id;
    logic [HashW-1:0]  data_hash;
  } item_t;

  // Update bundle broadcast to every channel slice
  typedef struct packed {
    logic              feed_en;
    logic [HashW-1:0]  data_hash;
    logic [TimeW-1:0]  now;
    logic [TimeW-1:0]  now_next;
  } upd_t;

endpackage

// ----- hw/rtl/stuck_sensor_data_watchdog_unit.sv -----
// Stuck sensor data watchdog, top level.
// An input item passes the input register and then the result register before its result is valid.
// Throughput: one item per cycle while the result is not stalled; each channel slice has its own subtract-compare.
// Reset: counter, hashes and change times clear to zero, window to 60000.
// Depends on swdg_pkg, swdg_in_reg and swdg_chan.
module stuck_sensor_data_watchdog_unit #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      func_i,
  input  logic [swdg_pkg::IdW-1:0]        sensor_id_i,
  input  logic [swdg_pkg::HashW-1:0]      data_hash_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            reset_request_o,
  output logic [swdg_pkg::MaskW-1:0]      stale_mask_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swdg_pkg::TimeW-1:0]      cfg_window_ms_i
);
  import swdg_pkg::*;

  localparam logic [MaskW-1:0] ChanMask = MaskW'((9'd1 << CHANNELS) - 9'd1);

  item_t            in_item, s1_item;
  logic             s1_valid, out_ready, advance;
  logic [TimeW-1:0] window_q;
  logic [TimeW-1:0] now_q, now_d;
  logic             in_range;
  logic [MaskW-1:0] stale;
  logic             request;
  upd_t             upd;
  logic             out_valid_q;
  logic             req_q;
  logic [MaskW-1:0] mask_q;

  assign in_item.func      = func_e'(func_i);
  assign in_item.sensor_id = sensor_id_i;
  assign in_item.data_hash = data_hash_i;

  swdg_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  // Result register frees when empty or taken
  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = s1_valid && out_ready;

  // Window register; always ready
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset;
    end else if (cfg_valid_i) begin
      window_q <= cfg_window_ms_i;
    end
  end

  // Advance the millisecond counter on a tick
  assign now_d = (advance && s1_item.func == FuncTick) ? now_q + 1'b1 : now_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else begin
      now_q <= now_d;
    end
  end

  assign in_range = (s1_item.sensor_id < IdW'(CHANNELS));

  // Channel slices
  for (genvar ch = 0; ch < MaskW; ch++) begin : g_chan
    if (ch < CHANNELS) begin : g_on
      upd_t upd_ch;
      always_comb begin
        upd_ch          = upd;
        upd_ch.feed_en  = upd.feed_en && (s1_item.sensor_id == IdW'(ch));
      end
      swdg_chan u_chan (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .upd_i    (upd_ch),
        .window_i (window_q),
        .stale_o  (stale[ch])
      );
    end else begin : g_off
      assign stale[ch] = 1'b0;
    end
  end

  always_comb begin
    upd.feed_en   = advance && (s1_item.func == FuncFeed) && in_range;
    upd.data_hash = s1_item.data_hash;
    upd.now       = now_q;
    upd.now_next  = now_d;
  end

  // Request only on a check with every channel stale
  always_comb begin
    case (s1_item.func)
      FuncCheck: request = ((stale & ChanMask) == ChanMask);
      default:   request = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      req_q  <= request;
      mask_q <= stale;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reset_request_o = req_q;
  assign stale_mask_o    = mask_q;

endmodule

// ----- hw/rtl/swdg_in_reg.sv -----
// Input register of the stuck sensor data watchdog.
// Captures one item per transfer and holds it until the result stage takes it.
// Depends on swdg_pkg.
module swdg_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  swdg_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output swdg_pkg::item_t item_o
);
  import swdg_pkg::*;

  logic  valid_q, valid_d;
  logic  accept;
  item_t item_q;

  // Stall while a held item cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload; load on transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/swdg_chan.sv -----
// One sensor channel of the stuck sensor data watchdog.
// Holds the last hash and its change time, and flags the channel as stale.
// Depends on swdg_pkg.
module swdg_chan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  swdg_pkg::upd_t               upd_i,
  input  logic [swdg_pkg::TimeW-1:0]   window_i,
  output logic                         stale_o
);
  import swdg_pkg::*;

  logic [HashW-1:0] hash_q;
  logic [TimeW-1:0] time_q, time_d;
  logic [TimeW-1:0] elapsed;
  logic             change;

  // Restamp only when the fed hash differs from the stored one
  assign change = upd_i.feed_en && (upd_i.data_hash != hash_q);
  assign time_d = change ? upd_i.now : time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      time_q <= '0;
    end else if (change) begin
      hash_q <= upd_i.data_hash;
      time_q <= time_d;
    end
  end

  // Modular elapsed time against the state after this item
  assign elapsed = upd_i.now_next - time_d;
  assign stale_o = (elapsed >= window_i);

endmodule

// ----- hw/rtl/swdg_checker.sv -----
// Port-level checks for the stuck sensor data watchdog.
// Bound to stuck_sensor_data_watchdog_unit; depends on swdg_pkg.
module swdg_checker #(
  parameter int unsigned CHANNELS = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        reset_request_o,
  input logic [swdg_pkg::MaskW-1:0]  stale_mask_o
);
  import swdg_pkg::*;

  localparam logic [MaskW-1:0] ChanMask = MaskW'((9'd1 << CHANNELS) - 9'd1);

  // A request implies every channel reported stale
  a_req_all_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reset_request_o) |-> ((stale_mask_o & ChanMask) == ChanMask))
    else $error("reset request without all channels stale");

  // Bits above the channel count stay clear
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((stale_mask_o & ~ChanMask) == '0))
    else $error("stale bit set beyond channel count");

  // Input back-pressure only when the result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with result side free");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(reset_request_o) && $stable(stale_mask_o)))
    else $error("stalled result changed");

endmodule

bind stuck_sensor_data_watchdog_unit swdg_checker #(.CHANNELS(CHANNELS)) u_swdg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .reset_request_o (reset_request_o),
  .stale_mask_o    (stale_mask_o)
);
